// ===== rtl/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the tga rle packet decoder
// packet phase codes, register indexes, result record
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int PixelCountBitsDefault = 24;
  localparam int CfgDataBits           = 24;
  localparam int CfgIndexBits          = 2;

  localparam logic [CfgIndexBits-1:0] REG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CfgIndexBits-1:0] REG_PIXEL_COUNT     = 2'd1;

  localparam logic [2:0] BPP_RESET   = 3'd3;
  localparam logic [23:0] PIX_RESET  = 24'd1;

  // header split point and run bias
  localparam logic [7:0] RUN_FLAG_LIMIT = 8'd128;
  localparam logic [7:0] RUN_BIAS       = 8'd127;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_RAW    = 3'b010,
    PH_RUN    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        last_of_image;
    logic        overflow_error;
  } result_t;

endpackage

// ===== rtl/trd_in_if.sv =====
// ----------------------------------------------------------------------------
// trd_in_if: compressed byte channel
// valid/ready handshake carrying one stream byte per request
// ----------------------------------------------------------------------------
interface trd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== rtl/trd_out_if.sv =====
// ----------------------------------------------------------------------------
// trd_out_if: decoded pixel channel
// valid/ready handshake carrying one pixel value and its repeat count
// ----------------------------------------------------------------------------
interface trd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        last_of_image;
  logic        overflow_error;

  modport source (output valid, output pixel_value, output repeat_count,
                  output last_of_image, output overflow_error, input ready);
  modport sink (input valid, input pixel_value, input repeat_count,
                input last_of_image, input overflow_error, output ready);
endinterface

// ===== rtl/tga_rle_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_rle_packet_decoder: rle pixel stream to pixel/repeat records
// a completed pixel is registered into the output register, or into the skid stage while the receiver holds off
// throughput: one byte per cycle while the skid stage is empty
// reset: synchronous, registers to reset values, header phase, buffers empty
// ----------------------------------------------------------------------------
module tga_rle_packet_decoder
  import trd_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = PixelCountBitsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0]  cfg_data,
  trd_in_if.sink                  in_stream,
  trd_out_if.source               out_stream
);

  localparam int PCB = PIXEL_COUNT_BITS;
  // wide enough for both the register field and the counter
  localparam int EXT = (PCB > 24) ? PCB : 24;

  // configuration registers
  logic [2:0]  bytes_per_pixel;
  logic [23:0] pixel_count;

  // decoder state
  phase_t          packet_phase, packet_phase_next;
  logic [7:0]      packet_remaining, packet_remaining_next;
  logic [1:0]      byte_in_pixel, byte_in_pixel_next;
  logic [31:0]     pixel_assembly, pixel_assembly_next;
  logic [PCB-1:0]  pixels_done, pixels_done_next;
  logic            error_latched, error_latched_next;

  // output register plus skid stage
  logic    out_valid, skid_valid;
  result_t out_res, skid_res;

  // datapath
  logic            accept;
  logic            has_res;
  result_t         res;
  logic [1:0]      bpp_m1;
  logic [31:0]     assembled;
  logic [EXT-1:0]  pc_ext;
  logic [PCB-1:0]  total, left, rem_ext, n_ext;
  logic [7:0]      n;
  logic            last, err;
  logic            cfg_hit;

  assign accept   = in_stream.valid && in_stream.ready;
  // skid stage full is the only reason to hold off the byte stream
  assign in_stream.ready = !skid_valid;

  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_BYTES_PER_PIXEL || cfg_index == REG_PIXEL_COUNT);

  // clamp bytes per pixel to 1..4, kept as count minus one
  always_comb begin
    priority if (bytes_per_pixel == 3'd0) bpp_m1 = 2'd0;
    else if (bytes_per_pixel > 3'd4)      bpp_m1 = 2'd3;
    else                                  bpp_m1 = 2'(bytes_per_pixel - 3'd1);
  end

  // pixel total at counter width, zero acts as one
  assign pc_ext = EXT'(pixel_count);
  always_comb begin
    total = pc_ext[PCB-1:0];
    if (total == '0) total = PCB'(1);
  end

  // pixels left in the image, never below one
  assign left    = (pixels_done < total) ? PCB'(total - pixels_done) : PCB'(1);
  assign rem_ext = PCB'(packet_remaining);

  // current byte merged into its lane
  assign assembled = pixel_assembly | (32'(in_stream.in_byte) << {byte_in_pixel, 3'b000});

  always_comb begin
    // run packets clip to the pixels left; raw ones go a pixel at a time
    if (packet_phase == PH_RAW) begin
      last = (left == PCB'(1));
      err  = last && (packet_remaining > 8'd1);
      n    = 8'd1;
    end else begin
      err  = rem_ext > left;
      n    = err ? left[7:0] : packet_remaining;
      last = (PCB'(n) == left);
    end
  end
  assign n_ext = PCB'(n);

  always_comb begin
    packet_phase_next     = packet_phase;
    packet_remaining_next = packet_remaining;
    byte_in_pixel_next    = byte_in_pixel;
    pixel_assembly_next   = pixel_assembly;
    pixels_done_next      = pixels_done;
    error_latched_next    = error_latched;
    has_res               = 1'b0;
    res.pixel_value       = assembled;
    res.repeat_count      = n;
    res.last_of_image     = last;
    res.overflow_error    = err;

    if (cfg_hit) begin
      // any write to a mapped register restarts the image
      packet_phase_next     = PH_HEADER;
      packet_remaining_next = '0;
      byte_in_pixel_next    = '0;
      pixel_assembly_next   = '0;
      pixels_done_next      = '0;
      error_latched_next    = 1'b0;
    end else if (accept && !error_latched) begin
      if (packet_phase == PH_HEADER) begin
        // packet header: raw below the flag, run otherwise
        if (in_stream.in_byte < RUN_FLAG_LIMIT) begin
          packet_phase_next     = PH_RAW;
          packet_remaining_next = 8'(in_stream.in_byte + 8'd1);
        end else begin
          packet_phase_next     = PH_RUN;
          packet_remaining_next = 8'(in_stream.in_byte - RUN_BIAS);
        end
        byte_in_pixel_next  = '0;
        pixel_assembly_next = '0;
      end else if (byte_in_pixel < bpp_m1) begin
        // more bytes of this pixel to come
        pixel_assembly_next = assembled;
        byte_in_pixel_next  = 2'(byte_in_pixel + 2'd1);
      end else begin
        // pixel complete
        has_res             = 1'b1;
        byte_in_pixel_next  = '0;
        pixel_assembly_next = '0;
        if (err) begin
          error_latched_next    = 1'b1;
          packet_phase_next     = PH_HEADER;
          packet_remaining_next = '0;
        end else if (last) begin
          pixels_done_next      = '0;
          packet_phase_next     = PH_HEADER;
          packet_remaining_next = '0;
        end else begin
          packet_remaining_next = 8'(packet_remaining - n);
          pixels_done_next      = PCB'(pixels_done + n_ext);
          if (packet_remaining == n) packet_phase_next = PH_HEADER;
        end
      end
    end
  end

  // configuration and decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel  <= BPP_RESET;
      pixel_count      <= PIX_RESET;
      packet_phase     <= PH_HEADER;
      packet_remaining <= '0;
      byte_in_pixel    <= '0;
      pixel_assembly   <= '0;
      pixels_done      <= '0;
      error_latched    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_BYTES_PER_PIXEL) bytes_per_pixel <= cfg_data[2:0];
      if (cfg_we && cfg_index == REG_PIXEL_COUNT)     pixel_count     <= cfg_data[23:0];
      packet_phase     <= packet_phase_next;
      packet_remaining <= packet_remaining_next;
      byte_in_pixel    <= byte_in_pixel_next;
      pixel_assembly   <= pixel_assembly_next;
      pixels_done      <= pixels_done_next;
      error_latched    <= error_latched_next;
    end
  end

  // output register and skid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the skid entry once the held result is taken
      if (out_stream.ready) skid_valid <= 1'b0;
    end else if (has_res) begin
      if (!out_valid || out_stream.ready) out_valid  <= 1'b1;
      else                                skid_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_stream.ready) out_res <= skid_res;
    end else if (has_res) begin
      if (!out_valid || out_stream.ready) out_res  <= res;
      else                                skid_res <= res;
    end
  end

  assign out_stream.valid          = out_valid;
  assign out_stream.pixel_value    = out_res.pixel_value;
  assign out_stream.repeat_count   = out_res.repeat_count;
  assign out_stream.last_of_image  = out_res.last_of_image;
  assign out_stream.overflow_error = out_res.overflow_error;

`ifndef NO_ASSERTIONS
  // skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  // an overflow always ends the image
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.overflow_error |-> out_res.last_of_image)
    else $error("overflow result not marked last");

  // results never carry a zero repeat
  a_repeat_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.repeat_count != 8'd0)
    else $error("zero repeat count");

  // pixel counter stays below the image total
  a_done_below_total: assert property (@(posedge clk) disable iff (rst)
    pixels_done < total)
    else $error("pixel counter reached image total");

  // a latched error parks the decoder in header phase
  a_err_header: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> packet_phase == PH_HEADER && packet_remaining == 8'd0)
    else $error("error latched outside header phase");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the tga rle packet decoder
// feeds compressed byte streams (raw and run packets, clipped and cut-off
// packets, noise after an overflow) under several pixel formats and image
// sizes, predicts every pixel record in the bench and compares it field by
// field against the decoder output, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_top
  import trd_pkg::*;
();

  localparam int ITEM_TARGET     = 1450;  // decoded bytes before the stimulus stops
  localparam int CALM_FROM       = 1250;  // no idling past this point
  localparam int LONG_HOLD       = 300;   // receiver hold-off that backs up the decoder
  localparam int SETTLE_CYCLES   = 4;     // settle time before a register write
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no request moving at all
  localparam int REPORT_LIMIT    = 10;

  // index outside the register map, the decoder must ignore it
  localparam logic [CfgIndexBits-1:0] REG_UNUSED = 2'd3;

  typedef enum bit {ROW_BYTE, ROW_WRITE} row_kind_t;

  // one line of the directed script: a stream byte or a register write
  typedef struct packed {
    row_kind_t                kind;
    logic [CfgIndexBits-1:0]  reg_idx;
    logic [CfgDataBits-1:0]   value;   // stream byte in bits 7:0 for byte rows
    bit                       typed;   // expected record written out in the row
    result_t                  want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                    cfg_we;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [CfgDataBits-1:0]  cfg_data;

  trd_in_if  byte_ch ();
  trd_out_if pix_ch ();

  tga_rle_packet_decoder #(
    .PIXEL_COUNT_BITS(PixelCountBitsDefault)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stream  (byte_ch),
    .out_stream (pix_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // decoder shadow state, kept in step with every accepted request
  // --------------------------------------------------------------------------
  logic [2:0]  cfg_bpp;
  logic [23:0] cfg_pixels;
  phase_t      dec_phase;
  logic [7:0]  pkt_left;     // pixels still owed by the open packet
  logic [1:0]  byte_idx;     // next byte slot within the pixel
  logic [31:0] pix_acc;
  logic [23:0] pix_done;     // pixels finished in the current image
  bit          err_latched;

  result_t pending_pixels[$];  // pixel records predicted, not yet seen
  int      bytes_decoded = 0;  // bytes the decoder actually acted on
  int      mismatches = 0;
  bit      calm = 1'b0;
  int      holds_asked = 0;
  int      holds_done = 0;
  int      src_gap_pct = 0;
  int      src_win = 0;
  int      quiet_cycles = 0;

  // any valid register write throws away the packet in flight
  function automatic void restart_decoder();
    dec_phase   = PH_HEADER;
    pkt_left    = '0;
    byte_idx    = '0;
    pix_acc     = '0;
    pix_done    = '0;
    err_latched = 1'b0;
  endfunction

  // out of range pixel sizes clamp: 0 acts as 1, 5..7 act as 4
  function automatic int unsigned eff_bpp();
    if (cfg_bpp == 3'd0) return 1;
    if (cfg_bpp > 3'd4) return 4;
    return 32'(cfg_bpp);
  endfunction

  // advance the shadow decoder by one byte, returns 1 when a record comes out
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    int unsigned bpp_n, total, left, n;
    bit last, err;
    r = '0;
    if (err_latched) return 1'b0;  // everything dropped until a write
    if (dec_phase == PH_HEADER) begin
      if (b < RUN_FLAG_LIMIT) begin
        dec_phase = PH_RAW;
        pkt_left  = b + 8'd1;
      end else begin
        dec_phase = PH_RUN;
        pkt_left  = b - RUN_BIAS;
      end
      byte_idx = '0;
      pix_acc  = '0;
      return 1'b0;
    end
    bpp_n = eff_bpp();
    pix_acc |= 32'(b) << (8 * byte_idx);
    if (byte_idx + 32'd1 < bpp_n) begin
      byte_idx = byte_idx + 2'd1;
      return 1'b0;
    end
    // zero image size acts as one pixel
    total = (cfg_pixels == '0) ? 1 : 32'(cfg_pixels);
    left  = (pix_done < total) ? total - pix_done : 1;
    if (dec_phase == PH_RAW) begin
      n    = 1;
      last = (left == 1);
      err  = last && (pkt_left > 8'd1);
    end else begin
      // a run that passes the end is clipped to what is left
      err  = (pkt_left > left);
      n    = err ? left : 32'(pkt_left);
      last = (n == left);
    end
    r.pixel_value    = pix_acc;
    r.repeat_count   = 8'(n);
    r.last_of_image  = last;
    r.overflow_error = err;
    byte_idx = '0;
    pix_acc  = '0;
    if (err) begin
      err_latched = 1'b1;
      dec_phase   = PH_HEADER;
      pkt_left    = '0;
      return 1'b1;
    end
    pkt_left = pkt_left - 8'(n);
    pix_done = 24'(pix_done + n);
    if (pkt_left == '0) dec_phase = PH_HEADER;
    if (last) begin
      pix_done  = '0;
      dec_phase = PH_HEADER;
      pkt_left  = '0;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 8;
      default: return 35;
    endcase
  endfunction

  // pixel bytes lean toward all zeros and all ones now and then
  function automatic logic [7:0] rand_px();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // directed script: reset defaults, size extremes, both packet kinds,
  // clipping of raw and run packets, dropped bytes after an overflow,
  // clamped pixel size and a zero image size
  // --------------------------------------------------------------------------
  script_row_t directed_steps [0:26] = '{
    // reset state: 3 bytes per pixel, one pixel per image
    '{kind: ROW_BYTE, value: 24'h00, default: '0},
    '{kind: ROW_BYTE, value: 24'h11, default: '0},
    '{kind: ROW_BYTE, value: 24'h22, default: '0},
    '{kind: ROW_BYTE, value: 24'h33, typed: 1'b1,
      want: {32'h0033_2211, 8'd1, 1'b1, 1'b0}, default: '0},
    // run of 128 into a one pixel image: clipped, flagged
    '{kind: ROW_BYTE, value: 24'hFF, default: '0},
    '{kind: ROW_BYTE, value: 24'hFF, default: '0},
    '{kind: ROW_BYTE, value: 24'hFF, default: '0},
    '{kind: ROW_BYTE, value: 24'hFF, typed: 1'b1,
      want: {32'h00FF_FFFF, 8'd1, 1'b1, 1'b1}, default: '0},
    // widest pixel, largest image, longest run
    '{kind: ROW_WRITE, reg_idx: REG_BYTES_PER_PIXEL, value: 24'd4, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_PIXEL_COUNT, value: 24'hFF_FFFF, default: '0},
    '{kind: ROW_BYTE, value: 24'hFF, default: '0},
    '{kind: ROW_BYTE, value: 24'h00, default: '0},
    '{kind: ROW_BYTE, value: 24'h80, default: '0},
    '{kind: ROW_BYTE, value: 24'h7F, default: '0},
    '{kind: ROW_BYTE, value: 24'hFF, typed: 1'b1,
      want: {32'hFF7F_8000, 8'd128, 1'b0, 1'b0}, default: '0},
    // pixel size zero acts as one byte, raw packet of 5 into 3 pixels
    '{kind: ROW_WRITE, reg_idx: REG_BYTES_PER_PIXEL, value: 24'd0, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_PIXEL_COUNT, value: 24'd3, default: '0},
    '{kind: ROW_BYTE, value: 24'h04, default: '0},
    '{kind: ROW_BYTE, value: 24'hAA, typed: 1'b1,
      want: {32'h0000_00AA, 8'd1, 1'b0, 1'b0}, default: '0},
    '{kind: ROW_BYTE, value: 24'h55, typed: 1'b1,
      want: {32'h0000_0055, 8'd1, 1'b0, 1'b0}, default: '0},
    '{kind: ROW_BYTE, value: 24'h01, typed: 1'b1,
      want: {32'h0000_0001, 8'd1, 1'b1, 1'b1}, default: '0},
    // latched error: this byte is dropped
    '{kind: ROW_BYTE, value: 24'h02, default: '0},
    // zero image size acts as one pixel
    '{kind: ROW_WRITE, reg_idx: REG_PIXEL_COUNT, value: 24'd0, default: '0},
    '{kind: ROW_BYTE, value: 24'h80, default: '0},
    '{kind: ROW_BYTE, value: 24'h5A, typed: 1'b1,
      want: {32'h0000_005A, 8'd1, 1'b1, 1'b0}, default: '0},
    '{kind: ROW_BYTE, value: 24'h81, default: '0},
    '{kind: ROW_BYTE, value: 24'h01, typed: 1'b1,
      want: {32'h0000_0001, 8'd1, 1'b1, 1'b1}, default: '0}
  };

  // --------------------------------------------------------------------------
  // byte channel driver: one request per call, prediction on acceptance
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    result_t pred;
    bit      got, live;
    if (src_win == 0) begin
      src_gap_pct = pick_gap_pct();
      src_win     = $urandom_range(16, 96);
    end
    src_win--;
    if (!calm && $urandom_range(1, 100) <= src_gap_pct) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    live = !err_latched;
    got  = decode_byte(b, pred);
    // a typed row overrides the predicted record
    if (typed) pending_pixels.push_back(want);
    else if (got) pending_pixels.push_back(pred);
    if (live) bytes_decoded++;
    if (bytes_decoded >= CALM_FROM) calm = 1'b1;
  endtask

  // register writes only with the decoder drained and quiet
  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] val);
    byte_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // headers and partial pixels leave no record, give them time to land
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BYTES_PER_PIXEL) begin
      cfg_bpp = val[2:0];
      restart_decoder();
    end else if (idx == REG_PIXEL_COUNT) begin
      cfg_pixels = val[23:0];
      restart_decoder();
    end
  endtask

  // header then n_bytes of pixel data
  task automatic send_packet(input bit is_run, input int unsigned k,
                             input int unsigned n_bytes);
    send_byte(is_run ? 8'(k) + RUN_BIAS : 8'(k - 1), 1'b0, '0);
    repeat (n_bytes) send_byte(rand_px(), 1'b0, '0);
  endtask

  // one configuration, then mostly well formed packets that track the image
  // boundary, ending now and then in an overflow or a cut-off packet
  task automatic stream_phase(input int budget, input bit dense);
    logic [2:0]  bpp_w;
    logic [23:0] count_w;
    int unsigned img_size, img_left, k, bpp_n, cap, hi;
    int          phase_base, pick;
    bit          is_run;
    if (dense) begin
      bpp_w   = 3'd1;
      count_w = 24'hFF_FFFF;
    end else begin
      bpp_w = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'($urandom_range(1, 4));
      case ($urandom_range(0, 9))
        0: count_w = 24'hFF_FFFF;
        1: count_w = 24'd0;
        2: count_w = 24'($urandom_range(100, 400));
        default: count_w = 24'($urandom_range(1, 24));
      endcase
    end
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 24'($urandom));
    // upper data bits on the pixel size write are don't-care
    pick = dense ? 0 : $urandom_range(0, 2);
    if (pick != 2) write_reg(REG_BYTES_PER_PIXEL, {21'($urandom), bpp_w});
    if (pick != 1) write_reg(REG_PIXEL_COUNT, count_w);
    if (dense) holds_asked++;

    bpp_n      = eff_bpp();
    img_size   = (cfg_pixels == '0) ? 1 : 32'(cfg_pixels);
    img_left   = img_size;
    phase_base = bytes_decoded;
    while (bytes_decoded - phase_base < budget) begin
      is_run = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 99);
      cap    = (img_left < 128) ? img_left : 128;
      if (!dense && pick < 4 && img_left < 128) begin
        // packet longer than the pixels left in the image
        hi = (img_left + 3 > 128) ? 128 : img_left + 3;
        k  = is_run ? $urandom_range(img_left + 1, 128) : $urandom_range(img_left + 1, hi);
        send_packet(is_run, k, is_run ? bpp_n : k * bpp_n);
        // noise after the error latch
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
        return;
      end
      if (!dense && pick < 7) begin
        // cut off inside the first pixel, the next write restarts it
        send_packet(is_run, $urandom_range(1, cap), $urandom_range(0, bpp_n - 1));
        return;
      end
      if (is_run) begin
        case ($urandom_range(0, 3))
          0: k = cap;
          1: k = 1;
          default: k = $urandom_range(1, cap);
        endcase
        send_packet(1'b1, k, bpp_n);
      end else begin
        // long literal packets only for narrow pixels
        case ($urandom_range(0, 15))
          0: k = (bpp_n <= 2) ? cap : 1;
          1: k = (bpp_n <= 2) ? $urandom_range(1, cap) : 1;
          default: k = $urandom_range(1, (cap < 6) ? cap : 6);
        endcase
        send_packet(1'b0, k, k * bpp_n);
      end
      img_left -= k;
      if (img_left == 0) img_left = img_size;
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus: reset, directed script, pressure burst, random phases, drain
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cfg_we          <= 1'b0;
    cfg_index       <= REG_BYTES_PER_PIXEL;
    cfg_data        <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    cfg_bpp    = BPP_RESET;
    cfg_pixels = PIX_RESET;
    restart_decoder();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_WRITE) begin
        write_reg(directed_steps[i].reg_idx, directed_steps[i].value);
      end else begin
        send_byte(directed_steps[i].value[7:0], directed_steps[i].typed,
                  directed_steps[i].want);
      end
    end

    // one byte per pixel with the receiver held off: decoder backs up
    stream_phase(250, 1'b1);
    while (bytes_decoded < ITEM_TARGET) stream_phase($urandom_range(20, 150), 1'b0);

    byte_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // pixel channel receiver: random stall bursts, quiet windows, long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap_pct;
    int win;
    gap_pct = 0;
    win     = 0;
    pix_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (win == 0) begin
        gap_pct = pick_gap_pct();
        win     = $urandom_range(16, 96);
      end
      win--;
      if (holds_done < holds_asked) begin
        pix_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else if (!calm && $urandom_range(1, 100) <= gap_pct) begin
        pix_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      pix_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void report_mismatch(input string what, input result_t want,
                                          input result_t seen);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display({"%0t %s: expected value %h count %0d last %b ovf %b,",
                " got value %h count %0d last %b ovf %b"},
               $time, what, want.pixel_value, want.repeat_count, want.last_of_image,
               want.overflow_error, seen.pixel_value, seen.repeat_count,
               seen.last_of_image, seen.overflow_error);
  endfunction

  // compare each accepted pixel record with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      seen = {pix_ch.pixel_value, pix_ch.repeat_count, pix_ch.last_of_image,
              pix_ch.overflow_error};
      if (pending_pixels.size() == 0) begin
        report_mismatch("record with nothing pending", '0, seen);
      end else begin
        want = pending_pixels.pop_front();
        if (seen.pixel_value !== want.pixel_value ||
            seen.repeat_count !== want.repeat_count ||
            seen.last_of_image !== want.last_of_image ||
            seen.overflow_error !== want.overflow_error)
          report_mismatch("record differs", want, seen);
      end
    end
  end

  // any request on either channel or a register write counts as progress
  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== tga_rle_packet_decoder.f =====
rtl/trd_pkg.sv
rtl/trd_in_if.sv
rtl/trd_out_if.sv
rtl/tga_rle_packet_decoder.sv
verif/tb_top.sv
